### rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared constants, operation and status codes, and controller command type
// for the circular FIFO queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

   // default sizes
   localparam int MAX_ITEMS_DEFAULT = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   // fixed field widths
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;
   localparam int VALUE_BITS  = 32;
   localparam int CAP_BITS    = 5;

   // capacity after reset
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_STATUS = 2'd0;
   localparam logic [OP_BITS-1:0] OP_PUSH   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_POP    = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd3;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic execute;   // apply the item and load the result register
   } cmd_type;

endpackage

### rtl/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl
// Controller: sequences each item through capture and execute, and owns the
// request ready and the result valid flag.
// ----------------------------------------------------------------------------
module cfq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfq_pkg::cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // result register may be reloaded when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.execute = (state_ff == S_EXEC) && out_free;

   // advance state and track the pending result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/cfq_datapath.sv
// ----------------------------------------------------------------------------
// cfq_datapath
// Datapath: entry memory, front and rear pointers, count, capacity register
// and the result register.
// ----------------------------------------------------------------------------
module cfq_datapath #(
   parameter int MAX_ITEMS = cfq_pkg::MAX_ITEMS_DEFAULT,
   parameter int WORD_BITS = cfq_pkg::WORD_BITS_DEFAULT,
   parameter int CNT_BITS  = $clog2(MAX_ITEMS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cfq_pkg::cmd_type                    cmd,
   input  logic [cfq_pkg::OP_BITS-1:0]         req_operation,
   input  logic signed [cfq_pkg::VALUE_BITS-1:0] req_push_value,
   input  logic                                csr_valid,
   input  logic [cfq_pkg::CAP_BITS-1:0]        csr_capacity,
   output logic [cfq_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic signed [cfq_pkg::VALUE_BITS-1:0] rsp_front_value,
   output logic [CNT_BITS-1:0]                 rsp_item_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full
);

   localparam int IDX_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CMP_BITS = (CNT_BITS > cfq_pkg::CAP_BITS) ? CNT_BITS : cfq_pkg::CAP_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_ITEMS - 1);
   localparam logic [CMP_BITS-1:0] MAX_CMP  = CMP_BITS'(MAX_ITEMS);

   logic [WORD_BITS-1:0] mem [MAX_ITEMS];
   logic [WORD_BITS-1:0] rd_word_ff;

   logic [IDX_BITS-1:0] front_ff, front_in;
   logic [IDX_BITS-1:0] rear_ff, rear_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [cfq_pkg::CAP_BITS-1:0] cap_ff;

   logic [cfq_pkg::OP_BITS-1:0]    op_ff;
   logic [cfq_pkg::VALUE_BITS-1:0] value_ff;

   logic [cfq_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [cfq_pkg::VALUE_BITS-1:0]  front_val_ff, front_val_in;
   logic [CNT_BITS-1:0]             out_count_ff;
   logic                            empty_ff, full_ff, full_in;

   logic [CMP_BITS-1:0]  cap_ext, eff_cap, count_cmp, count_in_cmp;
   logic [63:0]          value_wide;
   logic [WORD_BITS-1:0] push_word;
   logic signed [WORD_BITS-1:0] rd_signed;
   logic signed [63:0]   rd_ext;
   logic                 at_cap, do_write;

   // clamp capacity into one to MAX_ITEMS
   always_comb begin
      cap_ext = CMP_BITS'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (cap_ext > MAX_CMP) begin
         eff_cap = MAX_CMP;
      end else begin
         eff_cap = cap_ext;
      end
   end

   // keep the low word bits of the pushed value; sign-extend the read word
   assign value_wide = {32'b0, value_ff};
   assign push_word  = value_wide[WORD_BITS-1:0];
   assign rd_signed  = rd_word_ff;
   assign rd_ext     = 64'(rd_signed);

   assign count_cmp = CMP_BITS'(count_ff);
   assign at_cap    = (count_cmp >= eff_cap);

   // work out next pointers, count and result fields
   always_comb begin
      front_in     = front_ff;
      rear_in      = rear_ff;
      count_in     = count_ff;
      status_in    = cfq_pkg::ST_DONE;
      do_write     = 1'b0;
      front_val_in = (count_ff != '0) ? rd_ext[cfq_pkg::VALUE_BITS-1:0] : '0;
      case (op_ff)
         cfq_pkg::OP_PUSH: begin
            if (at_cap) begin
               status_in = cfq_pkg::ST_FULL;
            end else begin
               do_write = 1'b1;
               rear_in  = (rear_ff == LAST_IDX) ? '0 : rear_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         cfq_pkg::OP_POP: begin
            if (count_ff == '0) begin
               status_in = cfq_pkg::ST_EMPTY;
            end else begin
               front_in = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         cfq_pkg::OP_CLEAR: begin
            front_in = rear_ff;
            count_in = '0;
         end
         default: begin
         end
      endcase
      count_in_cmp = CMP_BITS'(count_in);
      full_in      = (count_in_cmp >= eff_cap);
   end

   // hold memory contents; read the front entry every cycle
   always_ff @(posedge clock) begin
      rd_word_ff <= mem[front_ff];
      if (cmd.execute && do_write) begin
         mem[rear_ff] <= push_word;
      end
   end

   // hold pointers, count and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= cfq_pkg::CAP_RESET;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
         if (cmd.execute) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            count_ff <= count_in;
         end
      end
   end

   // latch the accepted item and load the result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         value_ff <= req_push_value;
      end
      if (cmd.execute) begin
         status_ff    <= status_in;
         front_val_ff <= front_val_in;
         out_count_ff <= count_in;
         empty_ff     <= (count_in == '0);
         full_ff      <= full_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_front_value = front_val_ff;
   assign rsp_item_count  = out_count_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

endmodule

### rtl/circular_fifo_queue.sv
// Each item is captured, then executed against the registered read of the front
// entry once the result register is free; no new item is accepted until the
// current one has executed.
// Reset clears pointers, count and the result flag, and sets capacity to 16;
// memory contents are left as they are.
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring-buffer FIFO of signed words with push, pop, clear and status items,
// a configurable capacity, and one result per item.
// ----------------------------------------------------------------------------
module circular_fifo_queue #(
   parameter int MAX_ITEMS = cfq_pkg::MAX_ITEMS_DEFAULT,
   parameter int WORD_BITS = cfq_pkg::WORD_BITS_DEFAULT,
   parameter int CNT_BITS  = $clog2(MAX_ITEMS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cfq_pkg::OP_BITS-1:0]           req_operation,
   input  logic signed [cfq_pkg::VALUE_BITS-1:0] req_push_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cfq_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic signed [cfq_pkg::VALUE_BITS-1:0] rsp_front_value,
   output logic [CNT_BITS-1:0]                   rsp_item_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cfq_pkg::CAP_BITS-1:0]          csr_capacity
);

   cfq_pkg::cmd_type cmd;

   // capacity writes are always taken
   assign csr_ready = 1'b1;

   cfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cfq_datapath #(
      .MAX_ITEMS (MAX_ITEMS),
      .WORD_BITS (WORD_BITS),
      .CNT_BITS  (CNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_push_value  (req_push_value),
      .csr_valid       (csr_valid),
      .csr_capacity    (csr_capacity),
      .rsp_status      (rsp_status),
      .rsp_front_value (rsp_front_value),
      .rsp_item_count  (rsp_item_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule
